>>> rtl/core/rmb_pkg.sv
// Shared types and constants for the read minimizer binner.
`timescale 1ns / 1ps

package rmb_pkg;

    // field widths fixed by the interface
    localparam int BASE_W     = 3;
    localparam int SYM_W      = 2;
    localparam int SIG_CFG_W  = 4;
    localparam int CUT_CFG_W  = 5;
    localparam int SKIP_CFG_W = 4;
    localparam int BIN_W      = 31;
    localparam int POS_W      = 12;
    localparam int BSN_W      = 4;

    // base codes and limits
    localparam logic [BASE_W-1:0]    BASE_N      = 3'd4;
    localparam logic [BSN_W-1:0]     BSN_MAX     = 4'd15;
    localparam logic [SIG_CFG_W-1:0] SIG_LEN_MIN = 4'd3;

    // register map (word index)
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_SIG_LEN  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MASK_CUT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SKIP     = 2'd2;

    // register reset values
    localparam logic [SIG_CFG_W-1:0]  SIG_LEN_RST  = 4'd8;
    localparam logic [CUT_CFG_W-1:0]  MASK_CUT_RST = 5'd0;
    localparam logic [SKIP_CFG_W-1:0] SKIP_RST     = 4'd0;

    // per-base control word handed from the front end to the back end
    typedef struct packed {
        logic [SYM_W-1:0] sym;     // 2-bit symbol, N folded to A
        logic             win;     // enough clean bases for a full window
        logic             upd;     // base lies within the maximum read length
        logic             last;    // final base of the read
        logic             many_n;  // N count reaches a third of the length
    } rmb_ctl_t;

    // status flags carried with a finished read
    typedef struct packed {
        logic fwd_found;
        logic rc_found;
        logic many_n;
    } rmb_flags_t;

endpackage

>>> rtl/core/read_minimizer_binner.sv
// Top level of the read minimizer binner: config registers, front, queue, back, result stage.
//
//  Channel   Direction  Signals                                     Moves
//  s_        in         s_valid/s_ready, s_base_code, s_last_base   one base per request
//  m_        out        m_valid/m_ready, m_bin_value,
//                       m_min_position, m_is_reverse                one result per read
//  APB       in/out     psel, penable, pwrite, paddr, pwdata,
//                       prdata, pready                              register access
//
//  One base per cycle while the queue has room, set by the back end's k-mer roll and compare.
//  A result passes the queue, snapshot and output registers after the last base is accepted.
//  Reset is synchronous, active low; it clears all read state and loads register defaults.
//  A stalled result holds in the output register; the result stage and the two-entry
//  queue absorb further bases, and s_ready drops only when the queue is full.
`timescale 1ns / 1ps

module read_minimizer_binner #(
    parameter int MAX_SIG_LEN  = 15,
    parameter int MAX_READ_LEN = 4096,
    parameter int MAX_SKIP     = 15
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // base input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rmb_pkg::BASE_W-1:0]    s_base_code,
    input  logic                          s_last_base,
    // result output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rmb_pkg::BIN_W-1:0]     m_bin_value,
    output logic [rmb_pkg::POS_W-1:0]     m_min_position,
    output logic                          m_is_reverse
);

    localparam int CW       = $clog2(MAX_READ_LEN + 1);
    localparam int PSW      = (CW > rmb_pkg::POS_W) ? CW : rmb_pkg::POS_W;
    localparam int SKIP_CAP = (1 << rmb_pkg::SKIP_CFG_W) - 1;
    localparam int SKIP_TOP = (MAX_SKIP < SKIP_CAP) ? MAX_SKIP : SKIP_CAP;
    localparam int DD       = SKIP_TOP + 1;
    localparam int KW       = 2 * MAX_SIG_LEN;
    localparam int CTL_W    = $bits(rmb_pkg::rmb_ctl_t);
    localparam int QW       = CTL_W + 2 * CW;

    logic [rmb_pkg::SIG_CFG_W-1:0]  sig_len_reg;
    logic [rmb_pkg::CUT_CFG_W-1:0]  cut_reg;
    logic [rmb_pkg::SKIP_CFG_W-1:0] skip_reg;
    logic                           cfg_wr;
    logic [rmb_pkg::SIG_CFG_W-1:0]  k_eff;
    logic [rmb_pkg::SKIP_CFG_W-1:0] skip_eff;

    logic                           push_valid, push_ready;
    rmb_pkg::rmb_ctl_t              push_ctl;
    logic [CW-1:0]                  push_t, push_len;
    logic [QW-1:0]                  push_data, pop_data;
    logic                           q_valid, q_ready;
    rmb_pkg::rmb_ctl_t              q_ctl;
    logic [CW-1:0]                  q_t, q_len;

    logic                           snap_valid, fin_ready;
    rmb_pkg::rmb_flags_t            snap_flags;
    logic [KW-1:0]                  snap_fwd_val, snap_rc_val;
    logic [PSW-1:0]                 snap_fwd_start, snap_rc_start;
    logic [CW-1:0]                  snap_len;
    logic [rmb_pkg::SIG_CFG_W-1:0]  snap_k;

    // register writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_len_reg <= rmb_pkg::SIG_LEN_RST;
            cut_reg     <= rmb_pkg::MASK_CUT_RST;
            skip_reg    <= rmb_pkg::SKIP_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                rmb_pkg::REG_SIG_LEN:  sig_len_reg <= pwdata[rmb_pkg::SIG_CFG_W-1:0];
                rmb_pkg::REG_MASK_CUT: cut_reg     <= pwdata[rmb_pkg::CUT_CFG_W-1:0];
                rmb_pkg::REG_SKIP:     skip_reg    <= pwdata[rmb_pkg::SKIP_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (paddr[3:2])
            rmb_pkg::REG_SIG_LEN:  prdata = 32'(sig_len_reg);
            rmb_pkg::REG_MASK_CUT: prdata = 32'(cut_reg);
            rmb_pkg::REG_SKIP:     prdata = 32'(skip_reg);
            default:               prdata = 32'd0;
        endcase
    end

    // clamp signature length and skip zone to what the hardware holds
    always_comb begin
        if (sig_len_reg < rmb_pkg::SIG_LEN_MIN) begin
            k_eff = rmb_pkg::SIG_LEN_MIN;
        end else if (sig_len_reg > rmb_pkg::SIG_CFG_W'(MAX_SIG_LEN)) begin
            k_eff = rmb_pkg::SIG_CFG_W'(MAX_SIG_LEN);
        end else begin
            k_eff = sig_len_reg;
        end
        skip_eff = (skip_reg > rmb_pkg::SKIP_CFG_W'(SKIP_TOP)) ?
                   rmb_pkg::SKIP_CFG_W'(SKIP_TOP) : skip_reg;
    end

    // front end
    rmb_front #(
        .MAX_READ_LEN (MAX_READ_LEN),
        .CW           (CW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .base_code  (s_base_code),
        .last_base  (s_last_base),
        .k_eff      (k_eff),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_ctl   (push_ctl),
        .push_t     (push_t),
        .push_len   (push_len)
    );

    assign push_data = {push_ctl, push_t, push_len};

    // decoupling queue
    rmb_queue #(
        .DW (QW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (pop_data)
    );

    assign q_ctl = pop_data[QW-1 -: CTL_W];
    assign q_t   = pop_data[2*CW-1 -: CW];
    assign q_len = pop_data[CW-1:0];

    // back end
    rmb_back #(
        .MAX_SIG_LEN (MAX_SIG_LEN),
        .DD          (DD),
        .CW          (CW),
        .PSW         (PSW)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_ctl          (q_ctl),
        .q_t            (q_t),
        .q_len          (q_len),
        .k_eff          (k_eff),
        .cut_bits       (cut_reg),
        .skip_eff       (skip_eff),
        .snap_valid     (snap_valid),
        .snap_ready     (fin_ready),
        .snap_flags     (snap_flags),
        .snap_fwd_val   (snap_fwd_val),
        .snap_fwd_start (snap_fwd_start),
        .snap_rc_val    (snap_rc_val),
        .snap_rc_start  (snap_rc_start),
        .snap_len       (snap_len),
        .snap_k         (snap_k)
    );

    // result stage
    rmb_finish #(
        .MAX_SIG_LEN (MAX_SIG_LEN),
        .CW          (CW),
        .PSW         (PSW)
    ) u_finish (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .snap_valid     (snap_valid),
        .snap_ready     (fin_ready),
        .snap_flags     (snap_flags),
        .snap_fwd_val   (snap_fwd_val),
        .snap_fwd_start (snap_fwd_start),
        .snap_rc_val    (snap_rc_val),
        .snap_rc_start  (snap_rc_start),
        .snap_len       (snap_len),
        .snap_k         (snap_k),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bin_value    (m_bin_value),
        .m_min_position (m_min_position),
        .m_is_reverse   (m_is_reverse)
    );

`ifndef SYNTHESIS
    // a last base leaves the queue only when the result stage can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready && q_ctl.last) |-> fin_ready)
        else $error("last base popped while result stage busy");

    // a fresh result follows a popped last base through the snapshot and output registers
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(q_valid && q_ready && q_ctl.last, 2))
        else $error("result without matching last base");

    // the N bin is always reported forward at position zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_bin_value == (rmb_pkg::BIN_W'(1) << {k_eff, 1'b0})))
        |-> ((m_min_position == '0) && !m_is_reverse))
        else $error("N bin with non-zero position or reverse flag");
`endif

endmodule

>>> rtl/core/rmb_front.sv
// Front end: accepts bases, classifies them and tracks length and N counts.
`timescale 1ns / 1ps

module rmb_front #(
    parameter int MAX_READ_LEN = 4096,
    parameter int CW           = 13
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [rmb_pkg::BASE_W-1:0]   base_code,
    input  logic                         last_base,
    input  logic [rmb_pkg::SIG_CFG_W-1:0] k_eff,
    output logic                         push_valid,
    input  logic                         push_ready,
    output rmb_pkg::rmb_ctl_t            push_ctl,
    output logic [CW-1:0]                push_t,
    output logic [CW-1:0]                push_len
);

    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                ncnt_reg, ncnt_next;
    logic [rmb_pkg::BSN_W-1:0]    bsn_reg, bsn_next;
    logic                         is_n;
    logic                         upd;
    logic                         take;
    logic [CW+1:0]                three_n;

    assign push_valid = in_valid;
    assign in_ready   = push_ready;
    assign take       = in_valid && push_ready;

    // classify the base and advance the per-read counters
    always_comb begin
        is_n       = base_code >= rmb_pkg::BASE_N;
        upd        = count_reg < CW'(MAX_READ_LEN);
        count_next = count_reg;
        ncnt_next  = ncnt_reg;
        bsn_next   = bsn_reg;
        if (upd) begin
            count_next = count_reg + CW'(1);
            if (is_n) begin
                ncnt_next = ncnt_reg + CW'(1);
                bsn_next  = '0;
            end else if (bsn_reg < rmb_pkg::BSN_MAX) begin
                bsn_next = bsn_reg + rmb_pkg::BSN_W'(1);
            end
        end
        // n >= len/3 is the same as 3n + 2 >= len
        three_n = (CW+2)'({ncnt_next, 1'b0}) + (CW+2)'(ncnt_next) + (CW+2)'(2);

        push_ctl.sym    = is_n ? '0 : base_code[rmb_pkg::SYM_W-1:0];
        push_ctl.win    = bsn_next >= k_eff;
        push_ctl.upd    = upd;
        push_ctl.last   = last_base;
        push_ctl.many_n = three_n >= (CW+2)'(count_next);
        push_t          = count_reg;
        push_len        = count_next;
    end

    // counters restart after the last base of each read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ncnt_reg  <= '0;
            bsn_reg   <= '0;
        end else if (take) begin
            if (last_base) begin
                count_reg <= '0;
                ncnt_reg  <= '0;
                bsn_reg   <= '0;
            end else begin
                count_reg <= count_next;
                ncnt_reg  <= ncnt_next;
                bsn_reg   <= bsn_next;
            end
        end
    end

endmodule

>>> rtl/core/rmb_queue.sv
// Two-entry request queue between the front and back ends.
`timescale 1ns / 1ps

module rmb_queue #(
    parameter int DW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  logic [DW-1:0] push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output logic [DW-1:0] pop_data
);

    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    logic [DW-1:0] mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic          push_ok;
    logic          pop_ok;

    assign push_ready = cnt_reg != QUEUE_DEPTH;
    assign pop_valid  = cnt_reg != 2'd0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push_ok    = push_valid && push_ready;
    assign pop_ok     = pop_valid && pop_ready;

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push_ok) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop_ok)  rd_ptr_reg <= ~rd_ptr_reg;
            if (push_ok && !pop_ok)      cnt_reg <= cnt_reg + 2'd1;
            else if (!push_ok && pop_ok) cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push_ok) mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> rtl/core/rmb_back.sv
// Back end: rolls both k-mers, delays forward windows and keeps per-strand minima.
`timescale 1ns / 1ps

module rmb_back #(
    parameter int MAX_SIG_LEN = 15,
    parameter int DD          = 16,
    parameter int CW          = 13,
    parameter int PSW         = 13
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  rmb_pkg::rmb_ctl_t              q_ctl,
    input  logic [CW-1:0]                  q_t,
    input  logic [CW-1:0]                  q_len,
    input  logic [rmb_pkg::SIG_CFG_W-1:0]  k_eff,
    input  logic [rmb_pkg::CUT_CFG_W-1:0]  cut_bits,
    input  logic [rmb_pkg::SKIP_CFG_W-1:0] skip_eff,
    output logic                           snap_valid,
    input  logic                           snap_ready,
    output rmb_pkg::rmb_flags_t            snap_flags,
    output logic [2*MAX_SIG_LEN-1:0]       snap_fwd_val,
    output logic [PSW-1:0]                 snap_fwd_start,
    output logic [2*MAX_SIG_LEN-1:0]       snap_rc_val,
    output logic [PSW-1:0]                 snap_rc_start,
    output logic [CW-1:0]                  snap_len,
    output logic [rmb_pkg::SIG_CFG_W-1:0]  snap_k
);

    localparam int KW  = 2 * MAX_SIG_LEN;
    localparam int DIW = (DD > 1) ? $clog2(DD) : 1;

    // signature check: low cutoff bits clear, no AAA/AAC head, no AA pair below
    function automatic logic sig_ok(
        input logic [KW-1:0]                 m,
        input logic [rmb_pkg::SIG_CFG_W-1:0] k,
        input logic [rmb_pkg::CUT_CFG_W-1:0] cut
    );
        logic [31:0] low_mask;
        logic [4:0]  top_sh;
        logic [KW:0] top_lim;
        logic        ok;
        low_mask = ~(32'hFFFF_FFFF << cut);
        top_sh   = {k, 1'b0} - 5'd5;
        top_lim  = (KW+1)'(1) << top_sh;
        ok       = ((32'(m) & low_mask) == 32'd0) && ((KW+1)'(m) >= top_lim);
        for (int j = 0; j + 2 < MAX_SIG_LEN; j++) begin
            if ((m[2*j +: 4] == 4'd0) && ((j + 2) < int'(k))) ok = 1'b0;
        end
        return ok;
    endfunction

    logic [KW-1:0]  fwd_kmer_reg, rc_kmer_reg;
    logic [KW-1:0]  fwd_step, rc_step;
    logic [DD-1:0]  dl_vld_reg, dl_vld_next;
    logic [KW-1:0]  dl_val_reg [DD];
    logic [KW-1:0]  fwd_best_reg, fwd_best_next;
    logic [KW-1:0]  rc_best_reg, rc_best_next;
    logic [PSW-1:0] fwd_start_reg, fwd_start_next;
    logic [PSW-1:0] rc_start_reg, rc_start_next;
    logic           fwd_found_reg, fwd_found_next;
    logic           rc_found_reg, rc_found_next;
    logic [4:0]     k2;
    logic [KW:0]    k_pow;
    logic [KW-1:0]  kmask;
    logic           fwd_ok, rc_ok, rc_in_zone;
    logic [DIW-1:0] rd_idx;
    logic           tap_vld;
    logic [KW-1:0]  tap_val;
    logic           pop;

    // a last base needs room in the result stage
    assign q_ready = !q_ctl.last || snap_ready;
    assign pop     = q_valid && q_ready;

    // rolled windows for this base
    always_comb begin
        k2       = {k_eff, 1'b0};
        k_pow    = (KW+1)'(1) << k2;
        kmask    = KW'(k_pow - (KW+1)'(1));
        fwd_step = {fwd_kmer_reg[KW-3:0], q_ctl.sym} & kmask;
        rc_step  = ((rc_kmer_reg >> 2) | (KW'(~q_ctl.sym) << (k2 - 5'd2))) & kmask;
        fwd_ok   = sig_ok(fwd_step, k_eff, cut_bits);
        rc_ok    = sig_ok(rc_step, k_eff, cut_bits);
        rd_idx   = skip_eff[DIW-1:0];
        tap_vld  = dl_vld_reg[rd_idx];
        tap_val  = dl_val_reg[rd_idx];
        rc_in_zone = (CW+1)'(q_t) >= ((CW+1)'(k_eff) + (CW+1)'(skip_eff));
    end

    // minimum tracking on both strands
    always_comb begin
        fwd_best_next  = fwd_best_reg;
        fwd_start_next = fwd_start_reg;
        fwd_found_next = fwd_found_reg;
        rc_best_next   = rc_best_reg;
        rc_start_next  = rc_start_reg;
        rc_found_next  = rc_found_reg;
        dl_vld_next    = dl_vld_reg;
        if (q_ctl.upd) begin
            // forward window that has aged past the skip zone
            if (tap_vld && (!fwd_found_reg || (tap_val < fwd_best_reg))) begin
                fwd_best_next  = tap_val;
                fwd_start_next = PSW'(q_t) - PSW'(skip_eff) - PSW'(k_eff);
                fwd_found_next = 1'b1;
            end
            dl_vld_next[0] = q_ctl.win && fwd_ok;
            for (int i = 1; i < DD; i++) dl_vld_next[i] = dl_vld_reg[i-1];
            // reverse window; later equal values win
            if (q_ctl.win && rc_in_zone && rc_ok &&
                (!rc_found_reg || (rc_step <= rc_best_reg))) begin
                rc_best_next  = rc_step;
                rc_start_next = PSW'(q_t) + PSW'(1) - PSW'(k_eff);
                rc_found_next = 1'b1;
            end
        end
    end

    // finished read goes to the result stage
    always_comb begin
        snap_valid           = q_valid && q_ctl.last;
        snap_flags.fwd_found = fwd_found_next;
        snap_flags.rc_found  = rc_found_next;
        snap_flags.many_n    = q_ctl.many_n;
        snap_fwd_val         = fwd_best_next;
        snap_fwd_start       = fwd_start_next;
        snap_rc_val          = rc_best_next;
        snap_rc_start        = rc_start_next;
        snap_len             = q_len;
        snap_k               = k_eff;
    end

    // read state, cleared after each last base
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_kmer_reg  <= '0;
            rc_kmer_reg   <= '0;
            dl_vld_reg    <= '0;
            fwd_found_reg <= 1'b0;
            rc_found_reg  <= 1'b0;
        end else if (pop) begin
            if (q_ctl.last) begin
                fwd_kmer_reg  <= '0;
                rc_kmer_reg   <= '0;
                dl_vld_reg    <= '0;
                fwd_found_reg <= 1'b0;
                rc_found_reg  <= 1'b0;
            end else if (q_ctl.upd) begin
                fwd_kmer_reg  <= fwd_step;
                rc_kmer_reg   <= rc_step;
                dl_vld_reg    <= dl_vld_next;
                fwd_found_reg <= fwd_found_next;
                rc_found_reg  <= rc_found_next;
            end
        end
    end

    // window delay line and best-value payload
    always_ff @(posedge aclk) begin
        if (pop && q_ctl.upd) begin
            dl_val_reg[0] <= fwd_step;
            for (int i = 1; i < DD; i++) dl_val_reg[i] <= dl_val_reg[i-1];
            fwd_best_reg  <= fwd_best_next;
            fwd_start_reg <= fwd_start_next;
            rc_best_reg   <= rc_best_next;
            rc_start_reg  <= rc_start_next;
        end
    end

endmodule

>>> rtl/core/rmb_finish.sv
// Result stage: picks strand or N bin for a finished read and holds the result.
`timescale 1ns / 1ps

module rmb_finish #(
    parameter int MAX_SIG_LEN = 15,
    parameter int CW          = 13,
    parameter int PSW         = 13
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          snap_valid,
    output logic                          snap_ready,
    input  rmb_pkg::rmb_flags_t           snap_flags,
    input  logic [2*MAX_SIG_LEN-1:0]      snap_fwd_val,
    input  logic [PSW-1:0]                snap_fwd_start,
    input  logic [2*MAX_SIG_LEN-1:0]      snap_rc_val,
    input  logic [PSW-1:0]                snap_rc_start,
    input  logic [CW-1:0]                 snap_len,
    input  logic [rmb_pkg::SIG_CFG_W-1:0] snap_k,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rmb_pkg::BIN_W-1:0]     m_bin_value,
    output logic [rmb_pkg::POS_W-1:0]     m_min_position,
    output logic                          m_is_reverse
);

    localparam int KW = 2 * MAX_SIG_LEN;

    logic                          snap_v_reg;
    rmb_pkg::rmb_flags_t           flags_reg;
    logic [KW-1:0]                 fwd_val_reg, rc_val_reg;
    logic [PSW-1:0]                fwd_start_reg, rc_start_reg;
    logic [CW-1:0]                 len_reg;
    logic [rmb_pkg::SIG_CFG_W-1:0] k_reg;
    logic                          out_v_reg;
    logic [rmb_pkg::BIN_W-1:0]     bin_reg, bin_next;
    logic [rmb_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic                          rev_reg, rev_next;
    logic                          adv;
    logic                          load;
    logic [rmb_pkg::BIN_W-1:0]     n_bin, fv, rv;
    logic [PSW-1:0]                rc_pos;

    assign adv        = snap_v_reg && (!out_v_reg || m_ready);
    assign snap_ready = !snap_v_reg || adv;
    assign load       = snap_valid && snap_ready;

    assign m_valid        = out_v_reg;
    assign m_bin_value    = bin_reg;
    assign m_min_position = pos_reg;
    assign m_is_reverse   = rev_reg;

    // strand choice; forward wins ties, N bin forces forward at position 0
    always_comb begin
        n_bin  = rmb_pkg::BIN_W'(1) << {k_reg, 1'b0};
        fv     = (flags_reg.fwd_found && !flags_reg.many_n) ?
                 rmb_pkg::BIN_W'(fwd_val_reg) : n_bin;
        rv     = (flags_reg.rc_found && !flags_reg.many_n) ?
                 rmb_pkg::BIN_W'(rc_val_reg) : n_bin;
        rc_pos = PSW'(len_reg) - PSW'(k_reg) - rc_start_reg;
        if (fv <= rv) begin
            bin_next = fv;
            pos_next = fwd_start_reg[rmb_pkg::POS_W-1:0];
            rev_next = 1'b0;
        end else begin
            bin_next = rv;
            pos_next = rc_pos[rmb_pkg::POS_W-1:0];
            rev_next = 1'b1;
        end
        if (bin_next == n_bin) begin
            pos_next = '0;
            rev_next = 1'b0;
        end
    end

    // stage and output valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            if (load)     snap_v_reg <= 1'b1;
            else if (adv) snap_v_reg <= 1'b0;
            if (adv)          out_v_reg <= 1'b1;
            else if (m_ready) out_v_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            flags_reg     <= snap_flags;
            fwd_val_reg   <= snap_fwd_val;
            fwd_start_reg <= snap_fwd_start;
            rc_val_reg    <= snap_rc_val;
            rc_start_reg  <= snap_rc_start;
            len_reg       <= snap_len;
            k_reg         <= snap_k;
        end
        if (adv) begin
            bin_reg <= bin_next;
            pos_reg <= pos_next;
            rev_reg <= rev_next;
        end
    end

endmodule
